[rtl/core/ttl_pkg.sv]
`default_nettype none

package ttl_pkg;

  localparam int KEY_W  = 32;
  localparam int TIME_W = 31;
  localparam int EXP_W  = 32;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] CMD_GENERATE = 2'd0;
  localparam logic [1:0] CMD_RENEW    = 2'd1;
  localparam logic [1:0] CMD_COUNT    = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // request as it travels down the row of cells
  typedef struct packed {
    logic              active;
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic [EXP_W-1:0]  expiry;
    logic              found;
    logic              placed;
    logic [CNT_W-1:0]  cnt;
  } carry_t;

endpackage

`default_nettype wire

[rtl/core/ttl_cell.sv]
`default_nettype none

module ttl_cell (
  input  wire             clk,
  input  wire             rst,
  input  wire             advance,
  input  ttl_pkg::carry_t carry_in,
  output ttl_pkg::carry_t carry_out
);

  import ttl_pkg::*;

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [EXP_W-1:0] expiry;

  logic             hit;
  logic             do_insert;
  logic             do_renew;
  logic             valid_next;
  logic [EXP_W-1:0] expiry_next;
  logic             live;
  carry_t           carry_next;

  always_comb begin
    hit       = valid && (key == carry_in.key);
    do_insert = carry_in.active && (carry_in.cmd == CMD_GENERATE) && !valid &&
                !carry_in.found && !carry_in.placed;
    do_renew  = carry_in.active && (carry_in.cmd == CMD_RENEW) && hit;

    valid_next  = valid || do_insert;
    expiry_next = (do_insert || do_renew) ? carry_in.expiry : expiry;
    live        = valid_next && (expiry_next > {1'b0, carry_in.now});

    carry_next        = carry_in;
    carry_next.placed = carry_in.placed || do_insert;
    carry_next.found  = carry_in.found || (carry_in.active && hit &&
                        ((carry_in.cmd == CMD_GENERATE) || (carry_in.cmd == CMD_RENEW)));
    if (live && (carry_in.cnt != CNT_MAX)) begin
      carry_next.cnt = carry_in.cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      carry_out <= '0;
    end else if (advance) begin
      valid     <= valid_next;
      carry_out <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && do_insert) begin
      key <= carry_in.key;
    end
    if (advance) begin
      expiry <= expiry_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ttl_token_table.sv]
// ttl_token_table: table of token keys with expiry times.
// request channel (req_valid/req_ready): command, token_key, now.
//   generate adds an absent key with expiry now + lifetime in the lowest
//   free slot; renew updates the expiry of a present key; count changes
//   nothing. every request answers with status and live_count, the number
//   of entries whose expiry is greater than now after the request.
// response channel (rsp_valid/rsp_ready): status, live_count.
// config: cfg_write_en/cfg_write_data write the lifetime, only while idle.
// the user must keep to this; the block itself does not enforce it.
// the request travels down a row of TABLE_ENTRIES cells, one cell per
// cycle while the row is not held, each cell holding one entry; only one
// request is in flight, and the next is taken once it leaves the row.
// a new request is taken while the previous response waits in its output
// register; if that response is still not taken when the next one reaches
// the end of the row, the whole row holds until the receiver takes it.
// reset clears every entry, sets the lifetime to 1 and empties the channels.
`default_nettype none

module ttl_token_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           req_valid,
  output logic                          req_ready,
  input  wire  [1:0]                    command,
  input  wire  [ttl_pkg::KEY_W-1:0]     token_key,
  input  wire  [ttl_pkg::TIME_W-1:0]    now,
  output logic                          rsp_valid,
  input  wire                           rsp_ready,
  output logic [1:0]                    status,
  output logic [ttl_pkg::CNT_W-1:0]     live_count,
  input  wire                           cfg_write_en,
  input  wire  [ttl_pkg::TIME_W-1:0]    cfg_write_data
);

  import ttl_pkg::*;

  logic [TIME_W-1:0] lifetime;
  logic              busy;
  logic              advance;
  logic [1:0]        status_next;
  carry_t            carry [TABLE_ENTRIES+1];
  carry_t            tail;

  assign tail      = carry[TABLE_ENTRIES];
  assign advance   = !(tail.active && rsp_valid && !rsp_ready);
  assign req_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= {{(TIME_W-1){1'b0}}, 1'b1};
    end else if (cfg_write_en) begin
      lifetime <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry[0] <= '0;
    end else if (req_valid && req_ready) begin
      carry[0].active <= 1'b1;
      carry[0].cmd    <= command;
      carry[0].key    <= token_key;
      carry[0].now    <= now;
      carry[0].expiry <= {1'b0, now} + {1'b0, lifetime};
      carry[0].found  <= 1'b0;
      carry[0].placed <= 1'b0;
      carry[0].cnt    <= '0;
    end else if (advance) begin
      carry[0].active <= 1'b0;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ttl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1])
    );
  end

  always_comb begin
    case (tail.cmd)
      CMD_GENERATE: status_next = tail.found ? ST_IGNORED :
                                  (tail.placed ? ST_DONE : ST_FULL);
      CMD_RENEW:    status_next = tail.found ? ST_DONE : ST_IGNORED;
      CMD_COUNT:    status_next = ST_DONE;
      default:      status_next = ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        busy <= 1'b1;
      end else if (tail.active && advance) begin
        busy <= 1'b0;
      end
      if (tail.active && advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.active && advance) begin
      status     <= status_next;
      live_count <= tail.cnt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ttl_checker.sv]
`default_nettype none

module ttl_checker #(
  parameter int TABLE_ENTRIES = 64
) (
  input wire                        clk,
  input wire                        rst,
  input wire                        req_valid,
  input wire                        req_ready,
  input wire                        rsp_valid,
  input wire                        rsp_ready,
  input wire [1:0]                  status,
  input wire [ttl_pkg::CNT_W-1:0]   live_count
);

  import ttl_pkg::*;

  // one request in flight: no new request right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_DONE) || (status == ST_IGNORED) || (status == ST_FULL))
    else $error("unknown status code");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(live_count) <= 32'(TABLE_ENTRIES)))
    else $error("live count beyond table size");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(live_count))
    else $error("response dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("channels not empty after reset");

endmodule

bind ttl_token_table ttl_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ttl_checker (.*);

`default_nettype wire

[dv/ttl_token_table_tb.sv]
module ttl_token_table_tb;
  import ttl_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int KEY_POOL = 80;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 265;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] live_count;
  } outcome_t;

  typedef struct {
    bit                is_cfg;
    logic [1:0]        cmd;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] t;
    bit                typed;
    outcome_t          result;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [1:0] req_command = CMD_COUNT;
  logic [KEY_W-1:0] req_key = '0;
  logic [TIME_W-1:0] req_now = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [1:0] rsp_status;
  logic [CNT_W-1:0] rsp_live_count;
  logic cfg_write_en = 1'b0;
  logic [TIME_W-1:0] cfg_write_data = '0;

  bit idle_on = 1'b1;
  bit hold_off_request = 1'b0;
  int unsigned errors = 0;
  outcome_t pending_outcomes[$];

  // table as the block should hold it
  logic [TIME_W-1:0] lifetime = 31'd1;
  bit slot_used [TABLE_ENTRIES];
  logic [KEY_W-1:0] slot_key [TABLE_ENTRIES];
  logic [EXP_W-1:0] slot_expiry [TABLE_ENTRIES];

  logic [KEY_W-1:0] key_pool [KEY_POOL];
  logic [TIME_W-1:0] time_cursor = '0;
  step_row_t directed_steps [18];
  logic [TIME_W-1:0] phase_lifetime [PHASES];

  ttl_token_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .command(req_command),
    .token_key(req_key),
    .now(req_now),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .status(rsp_status),
    .live_count(rsp_live_count),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic outcome_t predict_outcome(input logic [1:0] cmd,
                                               input logic [KEY_W-1:0] key,
                                               input logic [TIME_W-1:0] t);
    outcome_t o;
    int hit;
    int free_slot;
    int live;
    logic [EXP_W-1:0] expiry;
    hit = -1;
    free_slot = -1;
    live = 0;
    expiry = {1'b0, t} + {1'b0, lifetime};
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
      if (!slot_used[i] && free_slot < 0) free_slot = i;
    end
    o.status = ST_IGNORED;
    case (cmd)
      CMD_GENERATE: begin
        if (hit < 0) begin
          if (free_slot < 0) begin
            o.status = ST_FULL;
          end else begin
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot] = key;
            slot_expiry[free_slot] = expiry;
            o.status = ST_DONE;
          end
        end
      end
      CMD_RENEW: begin
        if (hit >= 0) begin
          slot_expiry[hit] = expiry;
          o.status = ST_DONE;
        end
      end
      CMD_COUNT: begin
        o.status = ST_DONE;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i] && slot_expiry[i] > {1'b0, t} && live < int'(CNT_MAX)) live++;
    end
    o.live_count = CNT_W'(live);
    return o;
  endfunction

  task automatic issue_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                               input logic [TIME_W-1:0] t, input bit typed,
                               input outcome_t typed_out);
    outcome_t predicted;
    while (idle_on && $urandom_range(0, 99) < 11) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_command <= cmd;
    req_key <= key;
    req_now <= t;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = predict_outcome(cmd, key, t);
    pending_outcomes.push_back(typed ? typed_out : predicted);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_lifetime(input logic [TIME_W-1:0] value);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    lifetime = value;
  endtask

  initial begin : response_check
    outcome_t want;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("unexpected response: status %0d live_count %0d", rsp_status,
                 rsp_live_count);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp_status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp_status);
            errors++;
          end
          if (rsp_live_count !== want.live_count) begin
            $error("live_count expected %0d actual %0d", want.live_count, rsp_live_count);
            errors++;
          end
        end
      end
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= !(idle_on && $urandom_range(0, 99) < 11);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("ttl_token_table_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [TIME_W-1:0] t;
    int roll;
    int step_max;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_expiry[i] = '0;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h0000_0001;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;
    phase_lifetime = '{31'd16, 31'd1, 31'd1000, 31'($urandom_range(1, 32'h7FFF_FFFF)),
                       31'h7FFF_FFFF, 31'd250};
    directed_steps = '{
      '{0, CMD_COUNT,    32'h0000_0000, 31'd0,          1, '{ST_DONE,    7'd0}},
      '{0, CMD_GENERATE, 32'h0000_0000, 31'd0,          1, '{ST_DONE,    7'd1}},
      '{0, CMD_GENERATE, 32'h0000_0000, 31'd5,          1, '{ST_IGNORED, 7'd0}},
      '{0, CMD_RENEW,    32'hFFFF_FFFF, 31'd0,          1, '{ST_IGNORED, 7'd1}},
      '{0, CMD_RENEW,    32'h0000_0000, 31'd10,         1, '{ST_DONE,    7'd1}},
      '{0, CMD_UNUSED,   32'h0000_0000, 31'd11,         1, '{ST_IGNORED, 7'd0}},
      '{0, CMD_GENERATE, 32'hFFFF_FFFF, 31'h7FFF_FFFF,  1, '{ST_DONE,    7'd1}},
      // zero lifetime: a new entry is not live at the time it is written
      '{1, CMD_COUNT,    32'h0000_0000, 31'd0,          0, '{ST_DONE,    7'd0}},
      '{0, CMD_GENERATE, 32'h0000_0001, 31'd100,        0, '{ST_DONE,    7'd0}},
      '{0, CMD_RENEW,    32'hFFFF_FFFF, 31'd5,          0, '{ST_DONE,    7'd0}},
      '{1, CMD_COUNT,    32'h0000_0000, 31'h7FFF_FFFF,  0, '{ST_DONE,    7'd0}},
      '{0, CMD_RENEW,    32'h0000_0000, 31'h7FFF_FFFF,  0, '{ST_DONE,    7'd0}},
      '{0, CMD_GENERATE, 32'h8000_0000, 31'd0,          0, '{ST_DONE,    7'd0}},
      '{0, CMD_COUNT,    32'hAAAA_5555, 31'h7FFF_FFFE,  0, '{ST_DONE,    7'd0}},
      '{1, CMD_COUNT,    32'h0000_0000, 31'd1000,       0, '{ST_DONE,    7'd0}},
      '{0, CMD_UNUSED,   32'h0000_0001, 31'd0,          0, '{ST_DONE,    7'd0}},
      '{0, CMD_GENERATE, 32'h5555_AAAA, 31'h5555_5555,  0, '{ST_DONE,    7'd0}},
      '{0, CMD_COUNT,    32'h0000_1234, 31'h2AAA_AAAA,  0, '{ST_DONE,    7'd0}}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        write_lifetime(directed_steps[i].t);
      end else begin
        issue_request(directed_steps[i].cmd, directed_steps[i].key, directed_steps[i].t,
                      directed_steps[i].typed, directed_steps[i].result);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_lifetime(phase_lifetime[p]);
      idle_on = (p != 2);
      if (p == 1 || p == 4) hold_off_request = 1'b1;
      step_max = (lifetime < 31'd64) ? 8 : 40;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) cmd = CMD_GENERATE;
        else if (roll < 65) cmd = CMD_RENEW;
        else if (roll < 95) cmd = CMD_COUNT;
        else cmd = CMD_UNUSED;
        if ($urandom_range(0, 7) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          t = TIME_W'($urandom);
        end else begin
          time_cursor = time_cursor + TIME_W'($urandom_range(0, step_max));
          t = (roll < 25) ? time_cursor - TIME_W'($urandom_range(0, 60)) : time_cursor;
        end
        issue_request(cmd, key, t, 1'b0, '{ST_DONE, 7'd0});
      end
    end

    wait_drained();
    repeat (2 * TABLE_ENTRIES) @(posedge clk);
    if (errors == 0) begin
      $display("ttl_token_table_tb: PASS");
    end else begin
      $display("ttl_token_table_tb: FAIL");
    end
    $finish;
  end

endmodule
